/* sv/assert_macros.svh */
// Assertion macros for the RTL files that check their own behavior.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/mcca_pkg.sv */
// Types, constants and helper functions of the multichannel covariance accumulator.
// No dependencies; every other RTL file of the block imports this package.
package mcca_pkg;

  localparam int FIELD_W = 16;
  localparam int ACC_W   = 48;
  localparam int CNT_W   = 13;
  localparam int CHAN_W  = 2;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int MAX_CH  = 4;

  // Register word index, taken from paddr[2].
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  localparam logic [CNT_W-1:0] WINDOW_LENGTH_RESET = CNT_W'(256);

  typedef struct packed {
    logic signed [FIELD_W-1:0] ch0_re;
    logic signed [FIELD_W-1:0] ch0_im;
    logic signed [FIELD_W-1:0] ch1_re;
    logic signed [FIELD_W-1:0] ch1_im;
    logic signed [FIELD_W-1:0] ch2_re;
    logic signed [FIELD_W-1:0] ch2_im;
    logic signed [FIELD_W-1:0] ch3_re;
    logic signed [FIELD_W-1:0] ch3_im;
  } sample_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] term_value;
    logic [CHAN_W-1:0]       row_channel;
    logic [CHAN_W-1:0]       col_channel;
    logic                    is_imaginary;
    logic                    last_term;
  } term_item_t;

  // Control that the top level hands to every lane.
  typedef struct packed {
    logic adv;      // pipeline moves one step
    logic acc_en;   // a sample sits in the accumulate stage
    logic acc_clr;  // that sample closes its window
  } lane_ctl_t;

  // Position of a row's power term in emission order.
  function automatic int term_base(input int row, input int num_ch);
    return row * (2 * num_ch - row);
  endfunction

endpackage

/* sv/multichannel_covariance_accumulator.sv */
// Top level of the multichannel covariance accumulator: window control, register port,
// one lane per channel pair and the merging stage. Depends on mcca_pkg, mcca_lane,
// mcca_merge and assert_macros.svh.
`include "assert_macros.svh"

// Each sample transaction carries one complex Q1.15 sample for each of up to four
// channels, and the block takes one per clock cycle while sample_ready is high. One lane per
// channel pair (the pair of a channel with itself gives its power) forms the complex
// product a * conj(b) in two registered steps and adds it into 48-bit sums in the
// third, so a sample's share reaches the sums at the edge that registers that third step,
// and the first term of a window it closes is offered right after that edge. When the
// sample that closes a window reaches the sums, the lanes' totals are copied into the
// merging stage's buffer and the sums restart from zero in the same cycle. The buffer
// then sends CHAN_COUNT squared term transactions, one per cycle while term_ready
// is high, in row order: each row's power term first, then the real and imaginary
// parts of every later pair, with last_term set on the final one. A window of at
// least CHAN_COUNT squared samples and term_ready held high runs at one sample per cycle
// without pause; a shorter window, or a stalled term side, holds sample_ready low only
// when a closing sample finds the buffer still occupied, because the buffer is the
// single place a finished window waits. The window length register sits at byte
// address 0; zero acts as one, and lowering it mid-window closes the window on the next
// sample whose count reaches it. Writing the register never clears the sums or the count.
module multichannel_covariance_accumulator #(
  parameter int CHAN_COUNT  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  mcca_pkg::sample_item_t        sample,
  output logic                          term_valid,
  input  logic                          term_ready,
  output mcca_pkg::term_item_t          term,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcca_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcca_pkg::DATA_W-1:0]   pwdata,
  output logic [mcca_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mcca_pkg::*;

  localparam int TERMS = CHAN_COUNT * CHAN_COUNT;

  logic [CNT_W-1:0]             window_length;
  logic [CNT_W-1:0]             sample_count;
  logic [CNT_W-1:0]             count_next;
  logic [CNT_W-1:0]             limit;
  logic                         last_in;
  logic                         accept;
  logic                         adv;
  logic                         s1_valid;
  logic                         s1_last;
  logic                         s2_valid;
  logic                         s2_last;
  logic                         load;
  logic                         buf_free;
  lane_ctl_t                    lane_ctl;
  logic [FIELD_W-1:0]           raw_re [MAX_CH];
  logic [FIELD_W-1:0]           raw_im [MAX_CH];
  logic signed [SAMPLE_BITS-1:0] smp_re [CHAN_COUNT];
  logic signed [SAMPLE_BITS-1:0] smp_im [CHAN_COUNT];
  logic [TERMS-1:0][ACC_W-1:0]  term_sum;

  // Register port. pready stays high; the word index is paddr[2].
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_LENGTH) begin
      window_length <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? DATA_W'(window_length) : '0;

  // Samples use the low SAMPLE_BITS bits of each field, taken as two's complement;
  // a wider setting sees the 16-bit field as a non-negative value.
  assign raw_re = '{sample.ch0_re, sample.ch1_re, sample.ch2_re, sample.ch3_re};
  assign raw_im = '{sample.ch0_im, sample.ch1_im, sample.ch2_im, sample.ch3_im};

  for (genvar c = 0; c < CHAN_COUNT; c++) begin : g_chan
    assign smp_re[c] = SAMPLE_BITS'(raw_re[c]);
    assign smp_im[c] = SAMPLE_BITS'(raw_im[c]);
  end

  // The whole pipeline holds only while a closing sample waits for the buffer.
  assign load         = s2_valid && s2_last && buf_free;
  assign adv          = !(s2_valid && s2_last && !buf_free);
  assign sample_ready = adv;
  assign accept       = sample_valid && sample_ready;

  // Window counting happens at acceptance so the closing flag travels with the sample.
  assign count_next = sample_count + 1'b1;
  assign limit      = (window_length == '0) ? CNT_W'(1) : window_length;
  assign last_in    = !((count_next < limit) && (count_next != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (accept) begin
      sample_count <= last_in ? '0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
    end else if (adv) begin
      s1_valid <= sample_valid;
      s1_last  <= last_in;
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
    end
  end

  assign lane_ctl.adv     = adv;
  assign lane_ctl.acc_en  = adv && s2_valid;
  assign lane_ctl.acc_clr = s2_last;

  // One lane per channel pair with row <= column; its sums land at the pair's
  // place in emission order.
  for (genvar a = 0; a < CHAN_COUNT; a++) begin : g_row
    localparam int BASE = term_base(a, CHAN_COUNT);

    mcca_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_power (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .a_re   (smp_re[a]),
      .a_im   (smp_im[a]),
      .b_re   (smp_re[a]),
      .b_im   (smp_im[a]),
      .sum_re (term_sum[BASE]),
      .sum_im ()
    );

    for (genvar b = a + 1; b < CHAN_COUNT; b++) begin : g_col
      localparam int POS = BASE + 1 + 2 * (b - a - 1);

      mcca_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cross (
        .clk    (clk),
        .rst    (rst),
        .ctl    (lane_ctl),
        .a_re   (smp_re[a]),
        .a_im   (smp_im[a]),
        .b_re   (smp_re[b]),
        .b_im   (smp_im[b]),
        .sum_re (term_sum[POS]),
        .sum_im (term_sum[POS + 1])
      );
    end
  end

  mcca_merge #(
    .CHAN_COUNT (CHAN_COUNT)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .term_sum   (term_sum),
    .buf_free   (buf_free),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term)
  );

  // A sample that does not close its window leaves a nonzero count behind.
  `ASSERT_NEXT(a_count_advances, clk, rst, accept && !last_in, sample_count != '0)

  // A window's totals are only captured while nothing else is still leaving the buffer.
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, load, !term_valid || (term_ready && term.last_term))

  // Once the final term of a window leaves and no new window is captured, output idles.
  `ASSERT_NEXT(a_drain_ends, clk, rst,
    term_valid && term_ready && term.last_term && !load, !term_valid)

endmodule

/* sv/mcca_lane.sv */
// One lane: the complex product of a channel pair and its running sums.
// Depends on mcca_pkg.
module mcca_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mcca_pkg::lane_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS-1:0]  a_re,
  input  logic signed [SAMPLE_BITS-1:0]  a_im,
  input  logic signed [SAMPLE_BITS-1:0]  b_re,
  input  logic signed [SAMPLE_BITS-1:0]  b_im,
  output logic [mcca_pkg::ACC_W-1:0]     sum_re,
  output logic [mcca_pkg::ACC_W-1:0]     sum_im
);
  import mcca_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int COMB_W = PROD_W + 1;
  localparam int EXT_W  = (COMB_W > ACC_W) ? COMB_W : ACC_W;

  logic signed [PROD_W-1:0] p_rr;
  logic signed [PROD_W-1:0] p_ii;
  logic signed [PROD_W-1:0] p_ir;
  logic signed [PROD_W-1:0] p_ri;
  logic signed [EXT_W-1:0]  comb_re_ext;
  logic signed [EXT_W-1:0]  comb_im_ext;
  logic [ACC_W-1:0]         comb_re;
  logic [ACC_W-1:0]         comb_im;
  logic [ACC_W-1:0]         acc_re;
  logic [ACC_W-1:0]         acc_im;

  // Stage one: the four partial products.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ir <= a_im * b_re;
      p_ri <= a_re * b_im;
    end
  end

  assign comb_re_ext = EXT_W'(p_rr) + EXT_W'(p_ii);
  assign comb_im_ext = EXT_W'(p_ir) - EXT_W'(p_ri);

  // Stage two: real and imaginary parts of a * conj(b), wrapped to the sum width.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      comb_re <= comb_re_ext[ACC_W-1:0];
      comb_im <= comb_im_ext[ACC_W-1:0];
    end
  end

  assign sum_re = acc_re + comb_re;
  assign sum_im = acc_im + comb_im;

  // The sums restart from zero once a window's totals have been handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (ctl.acc_en) begin
      acc_re <= ctl.acc_clr ? '0 : sum_re;
      acc_im <= ctl.acc_clr ? '0 : sum_im;
    end
  end

endmodule

/* sv/mcca_merge.sv */
// Merging stage: captures every lane's window total and sends them out in row order.
// Depends on mcca_pkg.
module mcca_merge #(
  parameter int CHAN_COUNT = 4
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  load,
  input  logic [CHAN_COUNT*CHAN_COUNT-1:0][mcca_pkg::ACC_W-1:0] term_sum,
  output logic                                                  buf_free,
  output logic                                                  term_valid,
  input  logic                                                  term_ready,
  output mcca_pkg::term_item_t                                  term
);
  import mcca_pkg::*;

  localparam int TERMS = CHAN_COUNT * CHAN_COUNT;
  localparam int IDX_W = $clog2(TERMS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TERMS - 1);

  logic [ACC_W-1:0]  hold [TERMS];
  logic              busy;
  logic [IDX_W-1:0]  idx;
  logic [CHAN_W-1:0] row_tag  [TERMS];
  logic [CHAN_W-1:0] col_tag  [TERMS];
  logic              imag_tag [TERMS];

  for (genvar a = 0; a < CHAN_COUNT; a++) begin : g_row
    localparam int BASE = term_base(a, CHAN_COUNT);
    assign row_tag[BASE]  = CHAN_W'(a);
    assign col_tag[BASE]  = CHAN_W'(a);
    assign imag_tag[BASE] = 1'b0;
    for (genvar b = a + 1; b < CHAN_COUNT; b++) begin : g_col
      localparam int POS = BASE + 1 + 2 * (b - a - 1);
      assign row_tag[POS]      = CHAN_W'(a);
      assign col_tag[POS]      = CHAN_W'(b);
      assign imag_tag[POS]     = 1'b0;
      assign row_tag[POS + 1]  = CHAN_W'(a);
      assign col_tag[POS + 1]  = CHAN_W'(b);
      assign imag_tag[POS + 1] = 1'b1;
    end
  end

  // The buffer can take a new window in the cycle its final term leaves.
  assign buf_free = !busy || (term_ready && idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int t = 0; t < TERMS; t++) begin
        hold[t] <= term_sum[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && term_ready) begin
      if (idx == LAST_IDX) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  assign term_valid        = busy;
  assign term.term_value   = hold[idx];
  assign term.row_channel  = row_tag[idx];
  assign term.col_channel  = col_tag[idx];
  assign term.is_imaginary = imag_tag[idx];
  assign term.last_term    = (idx == LAST_IDX);

endmodule

/* dv/tb.sv */
// Self-checking testbench for multichannel_covariance_accumulator.
// Depends on mcca_pkg and the block's RTL. It predicts every term transaction and
// checks each one as it leaves the block.
`timescale 1ns / 1ps

module tb;
  import mcca_pkg::*;

  // One window yields a power term per channel and a real and imaginary part per pair.
  localparam int NUM_TERMS    = MAX_CH * MAX_CH;
  localparam int PIPE_SETTLE  = 8;        // settling wait for accepted samples to reach the sums
  localparam int END_SETTLE   = 24;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 90;
  localparam int STALL_HOLD   = 300;
  localparam int MAX_SHOWN    = 10;
  localparam int LONGEST_WIN  = 4096;
  localparam int WIDE_WIN     = 16;

  localparam logic [ADDR_W-1:0] WINDOW_LENGTH_ADDR = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR         = {~REG_WINDOW_LENGTH, 2'b00};

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  sample_item_t        sample       = '0;
  logic                term_valid;
  logic                term_ready   = 1'b0;
  term_item_t          term;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  multichannel_covariance_accumulator u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .term_valid   (term_valid),
    .term_ready   (term_ready),
    .term         (term),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Twelve nanosecond clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the running sums in emission order, the number of samples taken
  // into the open window, and the window length register as the block should hold it.
  logic [ACC_W-1:0] cov_sums [NUM_TERMS];
  logic [CNT_W-1:0] window_fill = '0;
  logic [CNT_W-1:0] window_reg  = WINDOW_LENGTH_RESET;
  term_item_t       pending_terms [$];

  int  error_count   = 0;
  int  cycle_count   = 0;
  int  term_hold_len = 0;
  int  term_pause    = 0;
  bit  gaps_on       = 1'b1;
  bit  term_stalls_on = 1'b1;
  term_item_t oldest_term;

  initial begin
    foreach (cov_sums[i]) cov_sums[i] = '0;
  end

  // Idle lengths shared by both sides: mostly short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // Builds one sample transaction. Random fields lean on the extremes now and then so
  // that the largest products turn up often, and otherwise cover every bit pattern.
  function automatic sample_item_t make_sample(input bit extremes_only);
    sample_item_t s;
    int r;
    for (int i = 0; i < 2 * MAX_CH; i++) begin
      r = extremes_only ? $urandom_range(0, 1) : $urandom_range(0, 9);
      case (r)
        0:       s[i*FIELD_W +: FIELD_W] = 16'h8000;
        1:       s[i*FIELD_W +: FIELD_W] = 16'h7fff;
        2:       s[i*FIELD_W +: FIELD_W] = $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
        default: s[i*FIELD_W +: FIELD_W] = 16'($urandom);
      endcase
    end
    return s;
  endfunction

  // Adds one accepted sample into the predicted sums. When the sample closes the window,
  // the whole matrix is queued in row order and the sums and the fill count restart.
  task automatic accumulate_sample(input sample_item_t s);
    longint     re [MAX_CH];
    longint     im [MAX_CH];
    longint     prod;
    term_item_t t;
    logic [CNT_W-1:0] next_fill;
    logic [CNT_W-1:0] limit;
    int n;
    re[0] = $signed(s.ch0_re);  im[0] = $signed(s.ch0_im);
    re[1] = $signed(s.ch1_re);  im[1] = $signed(s.ch1_im);
    re[2] = $signed(s.ch2_re);  im[2] = $signed(s.ch2_im);
    re[3] = $signed(s.ch3_re);  im[3] = $signed(s.ch3_im);
    n = 0;
    for (int a = 0; a < MAX_CH; a++) begin
      prod = re[a] * re[a] + im[a] * im[a];
      cov_sums[n] = cov_sums[n] + ACC_W'(prod);
      n++;
      for (int b = a + 1; b < MAX_CH; b++) begin
        prod = re[a] * re[b] + im[a] * im[b];
        cov_sums[n] = cov_sums[n] + ACC_W'(prod);
        n++;
        prod = im[a] * re[b] - re[a] * im[b];
        cov_sums[n] = cov_sums[n] + ACC_W'(prod);
        n++;
      end
    end

    // A zero length behaves as one; a count that reaches or passes the length closes.
    next_fill = window_fill + 1'b1;
    limit = (window_reg == '0) ? CNT_W'(1) : window_reg;
    if (next_fill < limit && next_fill != '0) begin
      window_fill = next_fill;
    end else begin
      n = 0;
      for (int a = 0; a < MAX_CH; a++) begin
        for (int b = a; b < MAX_CH; b++) begin
          for (int part = 0; part < ((b == a) ? 1 : 2); part++) begin
            t.term_value   = cov_sums[n];
            t.row_channel  = CHAN_W'(a);
            t.col_channel  = CHAN_W'(b);
            t.is_imaginary = (part == 1);
            t.last_term    = (n == NUM_TERMS - 1);
            pending_terms.push_back(t);
            n++;
          end
        end
      end
      foreach (cov_sums[i]) cov_sums[i] = '0;
      window_fill = '0;
    end
  endtask

  // Offers one sample transaction, sometimes after a random idle stretch when gaps are on,
  // and returns at the edge where it is accepted. Valid stays high into the next call
  // so back-to-back transactions keep the input busy.
  task automatic send_sample(input sample_item_t s);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 30) ? idle_gap() : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    accumulate_sample(s);
  endtask

  // Drops valid, waits for every predicted term, then lets the pipeline empty out,
  // since samples that close no window give no sign of when they reach the sums.
  task automatic settle();
    sample_valid <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == WINDOW_LENGTH_ADDR) window_reg = data[CNT_W-1:0];
  endtask

  // Reads the window length back and compares it with the predicted register. The bus
  // is left idle first, so a read never follows a write in the same cycle.
  task automatic check_window_reg();
    logic [DATA_W-1:0] got;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WINDOW_LENGTH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[CNT_W-1:0] !== window_reg) begin
      error_count++;
      if (error_count <= MAX_SHOWN)
        $display("tb: window length read %0d, expected %0d", got[CNT_W-1:0], window_reg);
    end
  endtask

  // Upper data bits carry junk, since only the low bits of the register exist.
  task automatic set_window_length(input logic [CNT_W-1:0] len);
    logic [DATA_W-1:0] data;
    settle();
    data = $urandom;
    data[CNT_W-1:0] = len;
    write_reg(WINDOW_LENGTH_ADDR, data);
    check_window_reg();
  endtask

  // The reset length holds, and lowering it below the fill closes the window on the
  // next sample without clearing the partial sums.
  task automatic test_lowered_default_window();
    check_window_reg();
    repeat (3) send_sample(make_sample(1'b0));
    set_window_length(CNT_W'(2));
    send_sample(make_sample(1'b0));
  endtask

  // Window of one: every sample gives a full matrix, from extremes, zeros and all ones.
  task automatic test_single_sample_windows();
    set_window_length(CNT_W'(1));
    send_sample(sample_item_t'({8{16'h8000}}));
    send_sample(sample_item_t'({8{16'h7fff}}));
    send_sample(sample_item_t'({4{16'h8000, 16'h7fff}}));
    send_sample(sample_item_t'({2{16'h8000, 16'h7fff, 16'h7fff, 16'h8000}}));
    send_sample(sample_item_t'({8{16'h0000}}));
    send_sample(sample_item_t'({8{16'hffff}}));
  endtask

  // A zero length acts as one.
  task automatic test_zero_window();
    set_window_length('0);
    repeat (3) send_sample(make_sample(1'b0));
  endtask

  // A write to the unused word must leave the window length alone.
  task automatic test_unmapped_write();
    settle();
    write_reg(SPARE_ADDR, $urandom);
    check_window_reg();
    send_sample(make_sample(1'b0));
  endtask

  // A length past the usual range is taken as written; dropping it to zero mid-window
  // then closes the window on the next sample.
  task automatic test_oversized_window();
    set_window_length(CNT_W'(8191));
    repeat (4) send_sample(make_sample(1'b0));
    set_window_length('0);
    send_sample(make_sample(1'b0));
  endtask

  // A window of extreme samples fed back to back drives the sums well past 32 bits
  // and checks that they keep their full width.
  task automatic test_wide_sums();
    set_window_length(CNT_W'(WIDE_WIN));
    gaps_on = 1'b0;
    repeat (WIDE_WIN) send_sample(make_sample(1'b1));
    gaps_on = 1'b1;
  endtask

  // The term side holds off for a long stretch while one-sample windows keep arriving,
  // so the output buffer fills and the block must stall its sample input.
  task automatic test_stalled_terms();
    set_window_length(CNT_W'(1));
    gaps_on = 1'b0;
    term_hold_len <= STALL_HOLD;
    repeat (24) send_sample(make_sample(1'b0));
    gaps_on = 1'b1;
  endtask

  // Phases of random length settings. Most phases send whole windows, some leave a
  // partial one open for the next phase, whose length may already be passed. The last
  // phase is cut short so that the total stays at the planned count.
  task automatic test_random_windows();
    int sent;
    int len;
    int eff;
    int n;
    int r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55)      len = $urandom_range(1, 8);
      else if (r < 85) len = $urandom_range(9, 40);
      else if (r < 92) len = 0;
      else             len = $urandom_range(LONGEST_WIN + 1, 8191);
      set_window_length(CNT_W'(len));
      gaps_on        = ($urandom_range(0, 3) != 0);
      term_stalls_on = ($urandom_range(0, 3) != 0);
      if (len > 40) begin
        n = $urandom_range(1, 6);
      end else begin
        eff = (len == 0) ? 1 : len;
        n = eff * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, eff);
      end
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) send_sample(make_sample(1'b0));
      sent += n;
    end
    gaps_on        = 1'b1;
    term_stalls_on = 1'b1;
  endtask

  // Term side: a requested long hold comes first, then random stalls, or ready high.
  always @(posedge clk) begin
    if (term_hold_len > 0) begin
      term_ready    <= 1'b0;
      term_hold_len <= term_hold_len - 1;
    end else if (term_pause > 0) begin
      term_ready <= 1'b0;
      term_pause <= term_pause - 1;
    end else if (term_stalls_on && $urandom_range(0, 99) < 20) begin
      term_ready <= 1'b0;
      term_pause <= idle_gap() - 1;
    end else begin
      term_ready <= 1'b1;
    end
  end

  // Each accepted term transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && term_valid && term_ready) begin
      if (pending_terms.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("tb: term with none expected: value %0d row %0d col %0d im %0b last %0b",
                   term.term_value, term.row_channel, term.col_channel,
                   term.is_imaginary, term.last_term);
      end else begin
        oldest_term = pending_terms.pop_front();
        if (term.term_value !== oldest_term.term_value ||
            term.row_channel !== oldest_term.row_channel ||
            term.col_channel !== oldest_term.col_channel ||
            term.is_imaginary !== oldest_term.is_imaginary ||
            term.last_term !== oldest_term.last_term) begin
          error_count++;
          if (error_count <= MAX_SHOWN) begin
            $display("tb: term mismatch: expected value %0d row %0d col %0d im %0b last %0b",
                     oldest_term.term_value, oldest_term.row_channel,
                     oldest_term.col_channel, oldest_term.is_imaginary,
                     oldest_term.last_term);
            $display("tb:   got value %0d row %0d col %0d im %0b last %0b",
                     term.term_value, term.row_channel, term.col_channel,
                     term.is_imaginary, term.last_term);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lowered_default_window();
    test_single_sample_windows();
    test_zero_window();
    test_unmapped_write();
    test_oversized_window();
    test_wide_sums();
    test_stalled_terms();
    test_random_windows();

    settle();
    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/mcca_pkg.sv
sv/mcca_lane.sv
sv/mcca_merge.sv
sv/multichannel_covariance_accumulator.sv
dv/tb.sv
